/* hdl/assert_macros.svh */
// Assertion macros for modules that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/stat_pkg.sv */
// Types and constants of the sensor track aging table.
package stat_pkg;

   localparam int REQ_TYPE_W  = 2;
   localparam int SLOT_IN_W   = 3;
   localparam int KIND_W      = 2;
   localparam int TS_W        = 48;
   localparam int AGE_W       = 49;
   localparam int LIMIT_W     = 24;
   localparam int ID_W        = 32;
   localparam int COUNT_OUT_W = 4;
   localparam int CSR_IDX_W   = 2;

   // One slot entry in the table memory: kind, last time, invisible period.
   localparam int SLOT_WORD_W = KIND_W + TS_W + AGE_W;

   localparam logic [REQ_TYPE_W-1:0] REQ_MEAS = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_MISS = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_INIT = 2'd2;

   localparam logic [KIND_W-1:0] KIND_LIDAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RADAR  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CAMERA = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_LIDAR_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADAR_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_LIMIT = 2'd2;

   localparam logic [LIMIT_W-1:0] LIDAR_LIMIT_RST  = 24'd250000;
   localparam logic [LIMIT_W-1:0] RADAR_LIMIT_RST  = 24'd500000;
   localparam logic [LIMIT_W-1:0] CAMERA_LIMIT_RST = 24'd750000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;    // item transfer: latch it and update the scalar state
      logic rd_en;    // read the slot at rd_addr
      logic proc_en;  // slot at proc_addr has its data out of the memory
      logic load;     // move the result into the output register
   } stat_cmd_type;

endpackage

/* hdl/stat_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module stat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/stat_ctrl.sv */
// Controller: sequences one item through the slot walk and the result register.
module stat_ctrl
   import stat_pkg::*;
#(
   parameter int SLOT_COUNT = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output stat_cmd_type           cmd,
   output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rd_addr,
   output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] proc_addr
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              proc_en_ff;
   logic [SLOT_W-1:0] proc_addr_ff;
   logic              rsp_valid_ff;
   logic              start, rd_en, load;

   assign start = (state_ff == ST_IDLE) && req_valid;
   assign rd_en = (state_ff == ST_WALK) && (cnt_ff != CNT_W'(SLOT_COUNT));
   assign load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_WALK;
               cnt_in   = '0;
            end
         end
         ST_WALK: begin
            if (rd_en) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               // The last slot is processed in this cycle.
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         proc_en_ff   <= 1'b0;
         proc_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         proc_en_ff   <= rd_en;
         proc_addr_ff <= cnt_ff[SLOT_W-1:0];
         rsp_valid_ff <= load || (rsp_valid_ff && rsp_stall);
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rd_addr     = cnt_ff[SLOT_W-1:0];
   assign proc_addr   = proc_addr_ff;
   assign cmd.start   = start;
   assign cmd.rd_en   = rd_en;
   assign cmd.proc_en = proc_en_ff;
   assign cmd.load    = load;

endmodule

/* hdl/stat_dp.sv */
// Datapath: limits, scalar track state, slot table, per-slot aging and result register.
module stat_dp
   import stat_pkg::*;
#(
   parameter int SLOT_COUNT = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  stat_cmd_type                  cmd,
   input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rd_addr,
   input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] proc_addr,
   input  logic                          csr_wr,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [LIMIT_W-1:0]            csr_wdata,
   input  logic [REQ_TYPE_W-1:0]         req_type,
   input  logic [SLOT_IN_W-1:0]          req_sensor_slot,
   input  logic [KIND_W-1:0]             req_sensor_kind,
   input  logic [TS_W-1:0]               req_timestamp_us,
   output logic [ID_W-1:0]               rsp_track_num,
   output logic                          rsp_alive,
   output logic                          rsp_lidar_visible,
   output logic                          rsp_radar_visible,
   output logic                          rsp_camera_visible,
   output logic                          rsp_slot_visible,
   output logic [COUNT_OUT_W-1:0]        rsp_slot_count,
   output logic signed [TS_W-1:0]        rsp_tracking_period_us
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int CMP_W  = (SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W;

   // Configuration.
   logic [LIMIT_W-1:0] lidar_limit_ff, radar_limit_ff, camera_limit_ff;

   // Scalar track state.
   logic [TS_W-1:0]        fused_ff;
   logic signed [TS_W-1:0] period_ff, period_in;
   logic [ID_W-1:0]        next_id_ff, current_id_ff;
   logic                   alive_ff;
   logic [SLOT_COUNT-1:0]  valid_ff;

   // Item held for the walk.
   logic [REQ_TYPE_W-1:0] type_ff;
   logic [SLOT_IN_W-1:0]  slot_ff;
   logic [KIND_W-1:0]     kind_ff;
   logic [TS_W-1:0]       ts_ff;
   logic                  meas_ff;

   // Walk accumulators.
   logic [CNT_W-1:0] count_ff;
   logic             lidar_vis_ff, radar_vis_ff, camera_vis_ff, slot_vis_ff, any_ff;

   // Result register.
   logic [ID_W-1:0]        out_id_ff;
   logic                   out_alive_ff, out_lidar_ff, out_radar_ff, out_camera_ff;
   logic                   out_slot_vis_ff;
   logic [CNT_W-1:0]       out_count_ff;
   logic signed [TS_W-1:0] out_period_ff;

   // Slot memory.
   logic                   wr_en;
   logic [SLOT_WORD_W-1:0] wr_data, rd_data;

   // Per-slot processing.
   logic [KIND_W-1:0]       rd_kind, new_kind;
   logic [TS_W-1:0]         rd_time;
   logic signed [AGE_W-1:0] rd_unseen, new_unseen, age;
   logic [LIMIT_W-1:0]      limit;
   logic                    expire, old_valid, hit, new_valid, keep, new_vis;

   // Period update.
   logic signed [AGE_W-1:0]   gap;
   logic signed [AGE_W:0]     sum;
   logic                      start_meas;

   stat_ram #(
      .WIDTH (SLOT_WORD_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (proc_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign start_meas = ((req_type == REQ_MEAS) || (req_type == REQ_INIT))
                       && (req_sensor_kind != KIND_OTHER);

   // Tracking period: add the time since the last fused time, saturating to 48 bits.
   always_comb begin
      gap = $signed({1'b0, req_timestamp_us}) - $signed({1'b0, fused_ff});
      sum = $signed({{2{period_ff[TS_W-1]}}, period_ff}) + $signed({gap[AGE_W-1], gap});
      if (sum[AGE_W] != sum[TS_W-1] || sum[AGE_W-1] != sum[TS_W-1]) begin
         period_in = sum[AGE_W] ? {1'b1, {(TS_W-1){1'b0}}} : {1'b0, {(TS_W-1){1'b1}}};
      end else begin
         period_in = sum[TS_W-1:0];
      end
   end

   always_comb begin
      rd_kind   = rd_data[SLOT_WORD_W-1 -: KIND_W];
      rd_time   = rd_data[AGE_W +: TS_W];
      rd_unseen = $signed(rd_data[AGE_W-1:0]);
      age       = $signed({1'b0, ts_ff}) - $signed({1'b0, rd_time});
      case (rd_kind)
         KIND_LIDAR: limit = lidar_limit_ff;
         KIND_RADAR: limit = radar_limit_ff;
         default:    limit = camera_limit_ff;
      endcase
      expire    = age > $signed({{(AGE_W-LIMIT_W){1'b0}}, limit});
      old_valid = valid_ff[proc_addr];
      hit       = (CMP_W'(slot_ff) == CMP_W'(proc_addr));

      new_valid  = old_valid;
      new_kind   = rd_kind;
      new_unseen = rd_unseen;
      keep       = 1'b0;
      wr_en      = 1'b0;
      if (meas_ff) begin
         if (hit) begin
            new_valid  = 1'b1;
            new_kind   = kind_ff;
            new_unseen = '0;
            wr_en      = cmd.proc_en;
         end else if (old_valid && expire) begin
            new_valid = 1'b0;
         end
      end else if ((type_ff == REQ_MISS) && old_valid) begin
         if (hit || (rd_unseen > 0)) begin
            new_unseen = age;
            wr_en      = cmd.proc_en;
         end
         new_valid = !expire;
         keep      = !expire;
      end
      wr_data = meas_ff ? {kind_ff, ts_ff, {AGE_W{1'b0}}} : {rd_kind, rd_time, new_unseen};
      // Visible means an invisible period of zero or less.
      new_vis = new_valid && (new_unseen[AGE_W-1] || (new_unseen == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lidar_limit_ff  <= LIDAR_LIMIT_RST;
         radar_limit_ff  <= RADAR_LIMIT_RST;
         camera_limit_ff <= CAMERA_LIMIT_RST;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_LIDAR_LIMIT:  lidar_limit_ff  <= csr_wdata;
            CSR_RADAR_LIMIT:  radar_limit_ff  <= csr_wdata;
            CSR_CAMERA_LIMIT: camera_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fused_ff      <= '0;
         period_ff     <= '0;
         next_id_ff    <= ID_W'(1);
         current_id_ff <= '0;
         alive_ff      <= 1'b1;
         valid_ff      <= '0;
      end else begin
         if (cmd.start) begin
            if (req_type == REQ_INIT) begin
               valid_ff      <= '0;
               period_ff     <= '0;
               alive_ff      <= 1'b1;
               current_id_ff <= next_id_ff;
               next_id_ff    <= (next_id_ff == '1) ? ID_W'(1) : next_id_ff + 1'b1;
               fused_ff      <= req_timestamp_us;
            end else if (start_meas) begin
               period_ff <= period_in;
               alive_ff  <= 1'b1;
               fused_ff  <= req_timestamp_us;
            end
         end
         if (cmd.proc_en) begin
            valid_ff[proc_addr] <= new_valid;
         end
         if (cmd.load && (type_ff == REQ_MISS)) begin
            alive_ff <= any_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         type_ff       <= req_type;
         slot_ff       <= req_sensor_slot;
         kind_ff       <= req_sensor_kind;
         ts_ff         <= req_timestamp_us;
         meas_ff       <= start_meas;
         count_ff      <= '0;
         lidar_vis_ff  <= 1'b0;
         radar_vis_ff  <= 1'b0;
         camera_vis_ff <= 1'b0;
         slot_vis_ff   <= 1'b0;
         any_ff        <= 1'b0;
      end else if (cmd.proc_en) begin
         if (new_valid) begin
            count_ff <= count_ff + 1'b1;
         end
         if (new_vis) begin
            case (new_kind)
               KIND_LIDAR:  lidar_vis_ff  <= 1'b1;
               KIND_RADAR:  radar_vis_ff  <= 1'b1;
               KIND_CAMERA: camera_vis_ff <= 1'b1;
               default: ;
            endcase
            if (hit) begin
               slot_vis_ff <= 1'b1;
            end
         end
         if (keep) begin
            any_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_id_ff       <= current_id_ff;
         out_alive_ff    <= (type_ff == REQ_MISS) ? any_ff : alive_ff;
         out_lidar_ff    <= lidar_vis_ff;
         out_radar_ff    <= radar_vis_ff;
         out_camera_ff   <= camera_vis_ff;
         out_slot_vis_ff <= slot_vis_ff;
         out_count_ff    <= count_ff;
         out_period_ff   <= period_ff;
      end
   end

   assign rsp_track_num          = out_id_ff;
   assign rsp_alive              = out_alive_ff;
   assign rsp_lidar_visible      = out_lidar_ff;
   assign rsp_radar_visible      = out_radar_ff;
   assign rsp_camera_visible     = out_camera_ff;
   assign rsp_slot_visible       = out_slot_vis_ff;
   assign rsp_slot_count         = COUNT_OUT_W'(out_count_ff);
   assign rsp_tracking_period_us = out_period_ff;

endmodule

/* hdl/sensor_track_aging_table_top.sv */
// Top level of the sensor track aging table: controller, datapath and checks.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  type, slot, kind, timestamp
//   rsp_      out        rsp_valid / rsp_stall  id, alive, visibility, count, period
//   csr_      in         csr_valid / csr_ready  index, 24-bit limit
//
// After its transfer an item walks the slot table, one slot table read per cycle, each
// slot aged in the cycle after its read, and then its result is loaded into the result
// register. A new item is taken in the cycle after the last result is loaded; a result
// held by rsp_stall keeps the next item in its last cycle until that result transfers.
// Reset is synchronous; it clears all slot valid bits at once, so no clearing pass
// is needed. csr_ready is always high.
`include "assert_macros.svh"

module sensor_track_aging_table_top
   import stat_pkg::*;
#(
   parameter int SLOT_COUNT = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [REQ_TYPE_W-1:0]  req_type,
   input  logic [SLOT_IN_W-1:0]   req_sensor_slot,
   input  logic [KIND_W-1:0]      req_sensor_kind,
   input  logic [TS_W-1:0]        req_timestamp_us,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ID_W-1:0]        rsp_track_num,
   output logic                   rsp_alive,
   output logic                   rsp_lidar_visible,
   output logic                   rsp_radar_visible,
   output logic                   rsp_camera_visible,
   output logic                   rsp_slot_visible,
   output logic [COUNT_OUT_W-1:0] rsp_slot_count,
   output logic signed [TS_W-1:0] rsp_tracking_period_us,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [LIMIT_W-1:0]     csr_wdata
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   stat_cmd_type      cmd;
   logic [SLOT_W-1:0] rd_addr, proc_addr;
   logic              req_xfer, slot_vis_out, kind_vis, dead_out;

   assign csr_ready = 1'b1;

   stat_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .proc_addr (proc_addr)
   );

   stat_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .rd_addr                (rd_addr),
      .proc_addr              (proc_addr),
      .csr_wr                 (csr_valid && csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_type               (req_type),
      .req_sensor_slot        (req_sensor_slot),
      .req_sensor_kind        (req_sensor_kind),
      .req_timestamp_us       (req_timestamp_us),
      .rsp_track_num          (rsp_track_num),
      .rsp_alive              (rsp_alive),
      .rsp_lidar_visible      (rsp_lidar_visible),
      .rsp_radar_visible      (rsp_radar_visible),
      .rsp_camera_visible     (rsp_camera_visible),
      .rsp_slot_visible       (rsp_slot_visible),
      .rsp_slot_count         (rsp_slot_count),
      .rsp_tracking_period_us (rsp_tracking_period_us)
   );

   assign req_xfer     = req_valid && !req_stall;
   assign slot_vis_out = rsp_valid && rsp_slot_visible;
   assign kind_vis     = rsp_lidar_visible || rsp_radar_visible || rsp_camera_visible;
   assign dead_out     = rsp_valid && !rsp_alive;

   // After a transfer the block is busy walking the table.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_xfer, req_stall, "walk did not start")

   // A visible addressed slot makes its sensor kind visible too.
   `ASSERT_IMPLIES(a_slot_vis_kind, clock, reset, slot_vis_out, kind_vis, "no kind visible")

   // A track that is not alive has no valid slots left.
   `ASSERT_IMPLIES(a_dead_empty, clock, reset, dead_out, rsp_slot_count == '0, "dead with slots")

endmodule
